/* sv/tsc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_pkg
// Shared widths, constants and the item record that travels down the
// sine / cosine series pipeline.
// ----------------------------------------------------------------------------
package tsc_pkg;

  localparam int MAX_TERMS        = 10;
  localparam int RESULT_FRAC_BITS = 32;

  localparam int FRAC_W  = 40;  // fraction bits of all internal values
  localparam int ANGLE_W = 26;
  localparam int CNT_W   = 4;
  localparam int OUT_W   = 48;
  localparam int MAG_W   = 58;  // term magnitudes and multiplier operand a
  localparam int X2_W    = 48;  // x squared and multiplier operand b
  localparam int SUM_W   = 60;
  localparam int RECIP_W = 40;

  // degrees to radians: x = amag * 157 * 2^21 / 1125, rounded
  localparam int DEG_SCALE = 157;
  localparam int DIV_CONST = 1125;
  localparam int DIV_BIAS  = 562;
  localparam int PRE_SHIFT = 21;
  localparam int DIV_SHIFT = 42;
  localparam logic [31:0] DIV_RECIP = 32'd3909374676;  // floor(2^42 / 1125)

  typedef struct packed {
    logic                    valid;
    logic                    kind;
    logic [CNT_W-1:0]        n;
    logic                    neg;       // sign of the current term
    logic [MAG_W-1:0]        term_mag;
    logic signed [SUM_W-1:0] sum;
    logic [X2_W-1:0]         x2;
  } tsc_item_t;

endpackage

/* sv/tsc_mul.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_mul
// Two-stage magnitude multiplier: four partial products, then sum, round to
// nearest and drop the fraction bits.
// ----------------------------------------------------------------------------
module tsc_mul
  import tsc_pkg::*;
(
  input  logic             clk,
  input  logic             en,
  input  logic [MAG_W-1:0] a,
  input  logic [X2_W-1:0]  b,
  output logic [MAG_W-1:0] p
);

  localparam int AH = MAG_W / 2;
  localparam int BH = X2_W / 2;
  localparam int PW = AH + BH;
  localparam int FW = MAG_W + X2_W;

  logic [PW-1:0] p00, p01, p10, p11;
  logic [FW-1:0] full;

  always_ff @(posedge clk) begin
    if (en) begin
      p00 <= PW'(a[AH-1:0])     * PW'(b[BH-1:0]);
      p01 <= PW'(a[AH-1:0])     * PW'(b[X2_W-1:BH]);
      p10 <= PW'(a[MAG_W-1:AH]) * PW'(b[BH-1:0]);
      p11 <= PW'(a[MAG_W-1:AH]) * PW'(b[X2_W-1:BH]);
    end
  end

  always_comb begin
    full = FW'(p00) + (FW'(p01) << BH) + (FW'(p10) << AH) + (FW'(p11) << (AH + BH))
         + (FW'(1) << (FRAC_W - 1));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p <= full[FRAC_W +: MAG_W];
    end
  end

endmodule

/* sv/tsc_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_front
// Degrees to radians by constant reciprocal division, then x squared, and
// the first series term for sine or cosine.
// ----------------------------------------------------------------------------
module tsc_front
  import tsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic                      kind,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  input  logic [CNT_W-1:0]          term_count,
  output tsc_item_t                 item
);

  typedef struct packed {
    logic             valid;
    logic             kind;
    logic [CNT_W-1:0] n;
    logic             neg;
  } side_t;

  side_t s1, s2, s3, s4, s5, s6, s7;
  logic [33:0] a1, a2;
  logic [65:0] p2;
  logic [23:0] q1_3, q1_4;
  logic [10:0] r1_3;
  logic [31:0] y4;
  logic [63:0] p4;
  logic [MAG_W-1:0] xmag5, xmag6, xmag7, x2_p;

  logic [ANGLE_W-1:0] amag;
  logic [23:0] q0a;
  logic [35:0] rem_a;
  logic [21:0] q0b;
  logic [33:0] rem_b;
  logic [21:0] q2;
  side_t s_in;

  always_comb begin
    amag = angle_deg[ANGLE_W-1] ? (~angle_deg + 1'b1) : angle_deg;
    s_in.valid = in_valid;
    s_in.kind  = kind;
    s_in.n     = (term_count > CNT_W'(MAX_TERMS)) ? CNT_W'(MAX_TERMS) : term_count;
    s_in.neg   = angle_deg[ANGLE_W-1];
    q0a   = p2[65:42];
    rem_a = 36'(a2) - 36'(q0a) * 36'(DIV_CONST);
    q0b   = p4[63:42];
    rem_b = 34'(y4) - 34'(q0b) * 34'(DIV_CONST);
    q2    = (rem_b >= 34'(DIV_CONST)) ? q0b + 22'd1 : q0b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= 34'(amag) * 34'(DEG_SCALE);
      a2   <= a1;
      p2   <= 66'(a1) * 66'(DIV_RECIP);
      if (rem_a >= 36'(DIV_CONST)) begin
        q1_3 <= q0a + 24'd1;
        r1_3 <= 11'(rem_a - 36'(DIV_CONST));
      end else begin
        q1_3 <= q0a;
        r1_3 <= 11'(rem_a);
      end
      q1_4 <= q1_3;
      y4   <= {r1_3, 21'b0} + 32'(DIV_BIAS);
      p4   <= 64'({r1_3, 21'b0} + 32'(DIV_BIAS)) * 64'(DIV_RECIP);
      xmag5 <= (MAG_W'(q1_4) << PRE_SHIFT) + MAG_W'(q2);
      xmag6 <= xmag5;
      xmag7 <= xmag6;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1.valid <= 1'b0; s2.valid <= 1'b0; s3.valid <= 1'b0; s4.valid <= 1'b0;
      s5.valid <= 1'b0; s6.valid <= 1'b0; s7.valid <= 1'b0;
    end else if (en) begin
      s1 <= s_in; s2 <= s1; s3 <= s2; s4 <= s3; s5 <= s4; s6 <= s5; s7 <= s6;
    end
  end

  tsc_mul u_sq (
    .clk (clk),
    .en  (en),
    .a   (xmag5),
    .b   (xmag5[X2_W-1:0]),
    .p   (x2_p)
  );

  always_comb begin
    item.valid = s7.valid;
    item.kind  = s7.kind;
    item.n     = s7.n;
    item.x2    = x2_p[X2_W-1:0];
    if (s7.kind) begin
      item.neg      = 1'b0;
      item.term_mag = MAG_W'(1) << FRAC_W;
      item.sum      = SUM_W'(1) << FRAC_W;
    end else begin
      item.neg      = s7.neg;
      item.term_mag = xmag7;
      item.sum      = s7.neg ? -$signed({2'b00, xmag7}) : $signed({2'b00, xmag7});
    end
  end

endmodule

/* sv/tsc_term.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsc_term
// One series step: term * x^2 * 1/d with alternating sign, added to the sum
// when the step lies within the requested count. Five register stages.
// ----------------------------------------------------------------------------
module tsc_term
  import tsc_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  tsc_item_t          in_item,
  input  logic [RECIP_W-1:0] recip,
  input  logic               active,
  output tsc_item_t          out_item
);

  tsc_item_t          d_item [4];
  logic [RECIP_W-1:0] d_recip [2];
  logic               d_act [4];
  logic [MAG_W-1:0]   mid, next_mag;
  logic signed [SUM_W-1:0] add;
  tsc_item_t          out_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_item[0].valid <= 1'b0;
      d_item[1].valid <= 1'b0;
      d_item[2].valid <= 1'b0;
      d_item[3].valid <= 1'b0;
      out_item.valid  <= 1'b0;
    end else if (en) begin
      d_item[0] <= in_item;   d_act[0] <= active;   d_recip[0] <= recip;
      d_item[1] <= d_item[0]; d_act[1] <= d_act[0]; d_recip[1] <= d_recip[0];
      d_item[2] <= d_item[1]; d_act[2] <= d_act[1];
      d_item[3] <= d_item[2]; d_act[3] <= d_act[2];
      out_item  <= out_next;
    end
  end

  tsc_mul u_x2 (
    .clk (clk),
    .en  (en),
    .a   (in_item.term_mag),
    .b   (in_item.x2),
    .p   (mid)
  );

  tsc_mul u_rc (
    .clk (clk),
    .en  (en),
    .a   (mid),
    .b   (X2_W'(d_recip[1])),
    .p   (next_mag)
  );

  // new term takes the opposite sign of the one it came from
  always_comb begin
    if (!d_act[3]) begin
      add = '0;
    end else if (d_item[3].neg) begin
      add = $signed({2'b00, next_mag});
    end else begin
      add = -$signed({2'b00, next_mag});
    end
  end

  always_comb begin
    out_next          = d_item[3];
    out_next.neg      = ~d_item[3].neg;
    out_next.term_mag = next_mag;
    out_next.sum      = d_item[3].sum + add;
  end

endmodule

/* sv/taylor_sine_cosine_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// taylor_sine_cosine_top
// Taylor series sine / cosine of an angle in degrees.
// ----------------------------------------------------------------------------
// Input beat: kind (0 sine, 1 cosine), angle_deg (signed Q10.16 degrees) and
// term_count (saturated at MAX_TERMS). Output beat: value (signed Q16.32)
// and saturated, one per input beat, in order.
// Radians use the factor 6.28/360. The pipeline has a front end (constant
// division and x squared), one step per series term (MAX_TERMS steps, each
// two pipelined multipliers) and one output register that rounds and clips.
// A new beat may enter every cycle while in_stall is low; one beat per cycle
// is sustained while out_stall is low.
// The whole pipeline advances together; it holds only while out_valid is
// high and out_stall is high, and then in_stall is raised, so nothing is
// dropped or repeated.
// Synchronous reset clears all valid bits; no results are pending after it.
// ----------------------------------------------------------------------------
module taylor_sine_cosine_top
  import tsc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      kind,
  input  logic signed [ANGLE_W-1:0] angle_deg,
  input  logic [CNT_W-1:0]          term_count,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [OUT_W-1:0]   value,
  output logic                      saturated
);

  localparam int Sh = FRAC_W - RESULT_FRAC_BITS;
  localparam logic [SUM_W:0] RoundAdd = ((SUM_W+1)'(1) << Sh) >> 1;
  localparam logic signed [SUM_W+1:0] OutHi = ((SUM_W+2)'(1) <<< (OUT_W - 1)) - 1;
  localparam logic signed [SUM_W+1:0] OutLo = -((SUM_W+2)'(1) <<< (OUT_W - 1));

  logic      advance;
  tsc_item_t stage_io [MAX_TERMS+1];

  logic [SUM_W-1:0]        mag;
  logic [SUM_W:0]          rnd;
  logic signed [SUM_W+1:0] sv;

  assign advance  = ~(out_valid & out_stall);
  assign in_stall = ~advance;

  tsc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .en         (advance),
    .in_valid   (in_valid),
    .kind       (kind),
    .angle_deg  (angle_deg),
    .term_count (term_count),
    .item       (stage_io[0])
  );

  for (genvar s = 1; s <= MAX_TERMS; s++) begin : g_term
    localparam longint unsigned Dc = longint'(2*s - 1) * longint'(2*s);
    localparam longint unsigned Ds = longint'(2*s) * longint'(2*s + 1);
    localparam longint unsigned RecC = ((64'd1 << FRAC_W) + Dc / 2) / Dc;
    localparam longint unsigned RecS = ((64'd1 << FRAC_W) + Ds / 2) / Ds;

    logic [RECIP_W-1:0] recip;
    logic               active;

    // cosine step s covers term s after the leading 1; sine step s is term s+1
    always_comb begin
      recip  = stage_io[s-1].kind ? RECIP_W'(RecC) : RECIP_W'(RecS);
      active = stage_io[s-1].kind ? (CNT_W'(s) <= stage_io[s-1].n)
                                  : (CNT_W'(s) <  stage_io[s-1].n);
    end

    tsc_term u_term (
      .clk      (clk),
      .rst      (rst),
      .en       (advance),
      .in_item  (stage_io[s-1]),
      .recip    (recip),
      .active   (active),
      .out_item (stage_io[s])
    );
  end

  always_comb begin
    mag = stage_io[MAX_TERMS].sum[SUM_W-1] ? SUM_W'(-stage_io[MAX_TERMS].sum)
                                           : SUM_W'(stage_io[MAX_TERMS].sum);
    rnd = ((SUM_W+1)'(mag) + RoundAdd) >> Sh;
    sv  = stage_io[MAX_TERMS].sum[SUM_W-1] ? -$signed({1'b0, rnd}) : $signed({1'b0, rnd});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= stage_io[MAX_TERMS].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      if (sv > OutHi) begin
        value     <= OUT_W'(OutHi);
        saturated <= 1'b1;
      end else if (sv < OutLo) begin
        value     <= OUT_W'(OutLo);
        saturated <= 1'b1;
      end else begin
        value     <= OUT_W'(sv);
        saturated <= 1'b0;
      end
    end
  end

endmodule
